/* design/polyline_box_intersect_select_assert.svh */
// assertion macros for the polyline box selection block
`ifndef POLYLINE_BOX_INTERSECT_SELECT_ASSERT_SVH
`define POLYLINE_BOX_INTERSECT_SELECT_ASSERT_SVH

// same-cycle implication
`define PBIS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbis assertion failed");

// next-cycle implication
`define PBIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbis assertion failed");

`endif

/* design/pbis_pkg.sv */
// shared types, constants and width helpers for the polyline box selection block
package pbis_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_AXES_DEF  = 256;

  localparam int XCFG_W  = 24;
  localparam int YCFG_W  = 20;
  localparam int VAL_W   = 20;
  localparam int AXIS_W  = 8;
  localparam int DY_W    = VAL_W + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] REG_X_LOW  = 2'd0;
  localparam logic [1:0] REG_X_HIGH = 2'd1;
  localparam logic [1:0] REG_Y_LOW  = 2'd2;
  localparam logic [1:0] REG_Y_HIGH = 2'd3;

  localparam logic [XCFG_W-1:0] X_LOW_RST  = 24'h000000;
  localparam logic [XCFG_W-1:0] X_HIGH_RST = 24'hFFFFFF;
  localparam logic [YCFG_W-1:0] Y_LOW_RST  = 20'h80000;
  localparam logic [YCFG_W-1:0] Y_HIGH_RST = 20'h7FFFF;

  typedef struct packed {
    logic [XCFG_W-1:0] x_low;
    logic [XCFG_W-1:0] x_high;
    logic [YCFG_W-1:0] y_low;
    logic [YCFG_W-1:0] y_high;
  } box_t;

  typedef struct packed {
    logic counted;
    logic last;
  } seg_ctl_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_stat_t;

  typedef struct packed {
    logic m_valid;
    logic m_last;
    logic adv;
    logic pop;
    logic acc;
  } back_stat_t;

  // unsigned width for axis positions and box edges
  function automatic int pos_w(input int frac);
    return (AXIS_W + frac + 1 > XCFG_W) ? AXIS_W + frac + 1 : XCFG_W;
  endfunction

  // signed width of the clipped x offsets
  function automatic int off_w(input int frac);
    return pos_w(frac) + 1;
  endfunction

  // signed width of the scaled box edge heights
  function automatic int edge_w(input int frac);
    return DY_W + frac;
  endfunction

  // signed width of the slope products
  function automatic int prod_w(input int frac);
    return DY_W + off_w(frac);
  endfunction

  // signed width of the side test terms
  function automatic int side_w(input int frac);
    return ((prod_w(frac) > edge_w(frac)) ? prod_w(frac) : edge_w(frac)) + 1;
  endfunction

endpackage

/* design/pbis_front.sv */
// front end: range check of the segment and clipping of the box to its x span
module pbis_front
  import pbis_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_AXES  = MAX_AXES_DEF
) (
  input  logic                              seg_valid,
  input  logic        [VAL_W-1:0]           left_value,
  input  logic        [VAL_W-1:0]           right_value,
  input  logic        [AXIS_W-1:0]          axis_number,
  input  logic                              row_selected,
  input  logic                              last_segment,
  input  box_t                              box,
  input  logic                              q_full,
  output logic                              seg_ready,
  output logic                              push,
  output seg_ctl_t                          ctl,
  output logic signed [DY_W-1:0]            dy,
  output logic signed [off_w(FRAC_BITS)-1:0]  dl,
  output logic signed [off_w(FRAC_BITS)-1:0]  dr,
  output logic signed [edge_w(FRAC_BITS)-1:0] top,
  output logic signed [edge_w(FRAC_BITS)-1:0] bot
);

  localparam int UW = pos_w(FRAC_BITS);

  logic [UW-1:0] xk, xkb, xl, xh, lo, hi, kk, kmin, kmax;
  logic signed [DY_W-1:0] y_ext, yb_ext, yl_ext, yh_ext, top_d, bot_d;
  logic in_range;

  assign kk   = UW'(axis_number);
  assign xk   = kk << FRAC_BITS;
  assign xkb  = (kk + UW'(1)) << FRAC_BITS;
  assign xl   = UW'(box.x_low);
  assign xh   = UW'(box.x_high);
  assign kmin = xl >> FRAC_BITS;
  assign kmax = xh >> FRAC_BITS;
  assign lo   = (xl > xk) ? xl : xk;
  assign hi   = (xh < xkb) ? xh : xkb;

  assign in_range = (kk >= kmin) && (kk <= kmax) && ((int'(axis_number) + 1) < MAX_AXES);

  assign dl = $signed({1'b0, lo}) - $signed({1'b0, xk});
  assign dr = $signed({1'b0, hi}) - $signed({1'b0, xk});

  assign y_ext  = $signed({left_value[VAL_W-1], left_value});
  assign yb_ext = $signed({right_value[VAL_W-1], right_value});
  assign yl_ext = $signed({box.y_low[YCFG_W-1], box.y_low});
  assign yh_ext = $signed({box.y_high[YCFG_W-1], box.y_high});

  assign dy    = yb_ext - y_ext;
  assign top_d = yh_ext - y_ext;
  assign bot_d = yl_ext - y_ext;
  assign top   = $signed({top_d, {FRAC_BITS{1'b0}}});
  assign bot   = $signed({bot_d, {FRAC_BITS{1'b0}}});

  assign ctl.counted = row_selected && in_range;
  assign ctl.last    = last_segment;

  assign seg_ready = !q_full;
  assign push      = seg_valid && !q_full;

endmodule

/* design/pbis_fifo.sv */
// short register queue between the front and back ends
module pbis_fifo
  import pbis_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output q_stat_t          stat
);

  logic [WIDTH-1:0]  mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign stat.count = count_r;
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + QPTR_W'(1) : rptr_r;
    count_nxt = count_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

/* design/pbis_back.sv */
// back end: slope products, side tests, row accumulation and result register
module pbis_back
  import pbis_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  input  seg_ctl_t                            ctl,
  input  logic signed [DY_W-1:0]              dy,
  input  logic signed [off_w(FRAC_BITS)-1:0]  dl,
  input  logic signed [off_w(FRAC_BITS)-1:0]  dr,
  input  logic signed [edge_w(FRAC_BITS)-1:0] top,
  input  logic signed [edge_w(FRAC_BITS)-1:0] bot,
  output logic                                pop,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic                                row_hit,
  output back_stat_t                          stat
);

  localparam int PW = prod_w(FRAC_BITS);
  localparam int TW = edge_w(FRAC_BITS);
  localparam int AW = side_w(FRAC_BITS);

  logic                 m_valid_r, m_valid_nxt;
  seg_ctl_t             m_ctl_r;
  logic signed [PW-1:0] pr_r, pl_r;
  logic signed [TW-1:0] top_r, bot_r;
  logic                 acc_r, acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic                 adv, consume, hit, acc_any;
  logic signed [AW-1:0] a, b, c, d;

  function automatic logic opposite(input logic signed [AW-1:0] p,
                                    input logic signed [AW-1:0] q);
    return (p == '0) || (q == '0) || (p[AW-1] != q[AW-1]);
  endfunction

  assign adv     = !m_valid_r || !m_ctl_r.last || !out_valid_r || res_ready;
  assign pop     = q_valid && adv;
  assign consume = m_valid_r && adv;

  assign a = AW'(top_r) - AW'(pr_r);
  assign b = AW'(bot_r) - AW'(pl_r);
  assign c = AW'(bot_r) - AW'(pr_r);
  assign d = AW'(top_r) - AW'(pl_r);

  assign hit     = m_ctl_r.counted && (opposite(a, b) || opposite(c, d));
  assign acc_any = acc_r || hit;

  always_comb begin
    m_valid_nxt   = adv ? q_valid : m_valid_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_hit_nxt   = out_hit_r;
    if (consume) begin
      if (m_ctl_r.last) begin
        out_valid_nxt = 1'b1;
        out_hit_nxt   = acc_any;
        acc_nxt       = 1'b0;
      end else begin
        acc_nxt = acc_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      m_valid_r   <= m_valid_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= out_hit_nxt;
    if (pop) begin
      m_ctl_r <= ctl;
      pr_r    <= PW'(dy) * PW'(dr);
      pl_r    <= PW'(dy) * PW'(dl);
      top_r   <= top;
      bot_r   <= bot;
    end
  end

  assign res_valid = out_valid_r;
  assign row_hit   = out_hit_r;

  assign stat.m_valid = m_valid_r;
  assign stat.m_last  = m_ctl_r.last;
  assign stat.adv     = adv;
  assign stat.pop     = pop;
  assign stat.acc     = acc_r;

endmodule

/* design/polyline_box_intersect_select.sv */
// top level of the polyline box selection block
// usage:
//   the in_ stream carries one polyline segment per transfer; in_tlast marks the
//   final segment of a row and in_tuser the row's input selection flag
//   the out_ stream carries one row result per transfer, only for rows that end
//   with in_tlast; bit 0 of out_tdata is set when a counted segment crosses the box
//   the user writes the box edges over the cfg_ port while no row is in flight; not enforced
// timing:
//   a segment transfer passes through the queue and the multiply stage register
//   into the result register, from which its row result is offered
//   one segment per cycle is sustained while no row result waits on out_tready,
//   with the queue read through its single read port into the multiply stage
// reset:
//   box edges return to the full range, the queue empties and the row
//   accumulator clears
// stall:
//   while out_tready is low the result holds; segments keep filling the four-entry
//   queue until it is full, then in_tready drops
`include "polyline_box_intersect_select_assert.svh"

module polyline_box_intersect_select
  import pbis_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_AXES  = MAX_AXES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // left_value[19:0], right_value[39:20], axis_number[47:40]
  input  logic        in_tuser,   // row_selected
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // row_hit[0], zero fill
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int XW = off_w(FRAC_BITS);
  localparam int TW = edge_w(FRAC_BITS);
  localparam int QW = 2 + DY_W + 2 * XW + 2 * TW;

  box_t box_r, box_nxt;
  logic cfg_wr;

  seg_ctl_t               f_ctl, b_ctl;
  logic signed [DY_W-1:0] f_dy, b_dy;
  logic signed [XW-1:0]   f_dl, f_dr, b_dl, b_dr;
  logic signed [TW-1:0]   f_top, f_bot, b_top, b_bot;
  logic                   push, pop, row_hit;
  logic [QW-1:0]          q_wdata, q_rdata;
  q_stat_t                q_stat;
  back_stat_t             b_stat;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    box_nxt = box_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_X_LOW:  box_nxt.x_low  = cfg_pwdata[XCFG_W-1:0];
        REG_X_HIGH: box_nxt.x_high = cfg_pwdata[XCFG_W-1:0];
        REG_Y_LOW:  box_nxt.y_low  = cfg_pwdata[YCFG_W-1:0];
        REG_Y_HIGH: box_nxt.y_high = cfg_pwdata[YCFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_X_LOW:  cfg_prdata = {8'd0, box_r.x_low};
      REG_X_HIGH: cfg_prdata = {8'd0, box_r.x_high};
      REG_Y_LOW:  cfg_prdata = {{12{box_r.y_low[YCFG_W-1]}}, box_r.y_low};
      REG_Y_HIGH: cfg_prdata = {{12{box_r.y_high[YCFG_W-1]}}, box_r.y_high};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.x_low  <= X_LOW_RST;
      box_r.x_high <= X_HIGH_RST;
      box_r.y_low  <= Y_LOW_RST;
      box_r.y_high <= Y_HIGH_RST;
    end else begin
      box_r <= box_nxt;
    end
  end

  pbis_front #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_AXES  (MAX_AXES)
  ) u_front (
    .seg_valid    (in_tvalid),
    .left_value   (in_tdata[19:0]),
    .right_value  (in_tdata[39:20]),
    .axis_number  (in_tdata[47:40]),
    .row_selected (in_tuser),
    .last_segment (in_tlast),
    .box          (box_r),
    .q_full       (q_stat.full),
    .seg_ready    (in_tready),
    .push         (push),
    .ctl          (f_ctl),
    .dy           (f_dy),
    .dl           (f_dl),
    .dr           (f_dr),
    .top          (f_top),
    .bot          (f_bot)
  );

  assign q_wdata = {f_ctl, f_dy, f_dl, f_dr, f_top, f_bot};
  assign {b_ctl, b_dy, b_dl, b_dr, b_top, b_bot} = q_rdata;

  pbis_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .pop   (pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  pbis_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_stat.empty),
    .ctl       (b_ctl),
    .dy        (b_dy),
    .dl        (b_dl),
    .dr        (b_dr),
    .top       (b_top),
    .bot       (b_bot),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .row_hit   (row_hit),
    .stat      (b_stat)
  );

  assign out_tdata = {7'd0, row_hit};

  // a segment taken while nothing leaves the queue is held in it
  `PBIS_ASSERT_NEXT(a_push_lands, in_tvalid && in_tready && !pop, q_stat.count != '0)
  // a result only appears after a last segment left the multiply stage
  `PBIS_ASSERT_IMPL(a_out_source, $rose(out_tvalid), $past(b_stat.m_valid && b_stat.m_last))
  // the row accumulator starts clear after every row end
  `PBIS_ASSERT_NEXT(a_acc_clear, b_stat.m_valid && b_stat.m_last && b_stat.adv, !b_stat.acc)

endmodule
